[hw/rtl/flow_vector_color_wheel_defines.svh]
// ----------------------------------------------------------------------------
// Flow vector color wheel assertion macros
// Shared property macros for the concurrent checks of the color wheel block.
// ----------------------------------------------------------------------------
`ifndef FLOW_VECTOR_COLOR_WHEEL_DEFINES_SVH
`define FLOW_VECTOR_COLOR_WHEEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FVCW_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FVCW_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/fvcw_pkg.sv]
// ----------------------------------------------------------------------------
// Flow vector color wheel package
// Color wheel table, arctangent table and shared constants.
// ----------------------------------------------------------------------------
package fvcw_pkg;

  localparam int WHEEL_SIZE = 55;
  localparam int SEG_RY = 15;
  localparam int SEG_YG = 6;
  localparam int SEG_GC = 4;
  localparam int SEG_CB = 11;
  localparam int SEG_BM = 13;
  localparam int SEG_MR = 6;
  localparam int COLOR_W = 8;
  localparam int WHEEL_IDX_W = 6;
  localparam int PHASE_W = 32;
  localparam int CVAL_W = 24;
  localparam logic [CVAL_W-1:0] FULL_Q16 = 24'hFF0000;
  localparam logic [WHEEL_IDX_W-1:0] WHEEL_LAST = 6'd54;
  localparam logic [5:0] WHEEL_SPAN = 6'd54;

  typedef logic [3*COLOR_W-1:0] wheel_tab_t [WHEEL_SIZE];

  function automatic wheel_tab_t build_wheel();
    wheel_tab_t t;
    int k;
    int j;
    int r;
    int g;
    int b;
    for (k = 0; k < WHEEL_SIZE; k++) begin
      j = k;
      r = 255;
      g = 0;
      b = 0;
      if (j < SEG_RY) begin
        g = 255 * j / SEG_RY;
      end else begin
        j = j - SEG_RY;
        if (j < SEG_YG) begin
          r = 255 - 255 * j / SEG_YG;
          g = 255;
        end else begin
          j = j - SEG_YG;
          if (j < SEG_GC) begin
            r = 0;
            g = 255;
            b = 255 * j / SEG_GC;
          end else begin
            j = j - SEG_GC;
            if (j < SEG_CB) begin
              r = 0;
              g = 255 - 255 * j / SEG_CB;
              b = 255;
            end else begin
              j = j - SEG_CB;
              if (j < SEG_BM) begin
                r = 255 * j / SEG_BM;
                b = 255;
              end else begin
                j = j - SEG_BM;
                b = 255 - 255 * j / SEG_MR;
              end
            end
          end
        end
      end
      t[k] = {8'(b), 8'(g), 8'(r)};
    end
    return t;
  endfunction

  localparam wheel_tab_t WHEEL_TAB = build_wheel();

  // Arctangent of 2^-i in turns, scaled by 2^32.
  function automatic logic [PHASE_W-1:0] atan_turns(input logic [4:0] i);
    logic [PHASE_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/fvcw_sqrt.sv]
// ----------------------------------------------------------------------------
// Flow magnitude unit
// Squares the flow components and takes the integer square root two bits
// of the radicand per cycle.
// ----------------------------------------------------------------------------
module fvcw_sqrt #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] x,
  input  logic signed [W-1:0] y,
  output logic                done,
  output logic [W-1:0]        root
);

  localparam int CW = $clog2(W + 1);

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_SUM, S_RUN} sq_state_t;

  sq_state_t       state;
  logic [W-1:0]    ax;
  logic [W-1:0]    ay;
  logic [2*W-1:0]  sqx;
  logic [2*W-1:0]  sqy;
  logic [2*W-1:0]  val;
  logic [W+1:0]    rem;
  logic [W+1:0]    rem_sh;
  logic [W+1:0]    trial;
  logic [CW-1:0]   cnt;

  assign ax = x[W-1] ? W'(~x + 1'b1) : W'(x);
  assign ay = y[W-1] ? W'(~y + 1'b1) : W'(y);
  assign rem_sh = {rem[W-1:0], val[2*W-1:2*W-2]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      if (done) begin
        done <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            sqx <= ax * ax;
            sqy <= ay * ay;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          val <= sqx + sqy;
          rem <= '0;
          root <= '0;
          cnt <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_RUN;
        end
        S_RUN: begin
          val <= {val[2*W-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem <= rem_sh - trial;
            root <= {root[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            root <= {root[W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/fvcw_cordic.sv]
// ----------------------------------------------------------------------------
// Flow phase unit
// CORDIC vectoring run, one micro-rotation per cycle, giving the flow angle
// in turns as a 32-bit fraction.
// ----------------------------------------------------------------------------
module fvcw_cordic #(
  parameter int W = 16,
  parameter int STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [W-1:0]             x,
  input  logic signed [W-1:0]             y,
  output logic                            done,
  output logic [fvcw_pkg::PHASE_W-1:0]    z
);

  localparam int XW = W + 3;
  localparam int IW = $clog2(STEPS);

  logic                busy;
  logic [IW-1:0]       i;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign xs = XW'(x);
  assign ys = XW'(y);
  assign dx = yr >>> i;
  assign dy = xr >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i <= '0;
      done <= 1'b0;
    end else if (busy) begin
      if (!yr[XW-1]) begin
        xr <= xr + dx;
        yr <= yr - dy;
        z <= z + fvcw_pkg::atan_turns(5'(i));
      end else begin
        xr <= xr - dx;
        yr <= yr + dy;
        z <= z - fvcw_pkg::atan_turns(5'(i));
      end
      i <= i + 1'b1;
      done <= (i == IW'(STEPS - 1));
      if (i == IW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end else if (start) begin
      i <= '0;
      done <= (y == '0) || (x == '0);
      if (y == '0) begin
        z <= x[W-1] ? 32'h80000000 : 32'h00000000;
      end else if (x == '0) begin
        z <= y[W-1] ? 32'hC0000000 : 32'h40000000;
      end else begin
        busy <= 1'b1;
        if (x[W-1]) begin
          xr <= -xs;
          yr <= -ys;
          z <= 32'h80000000;
        end else begin
          xr <= xs;
          yr <= ys;
          z <= '0;
        end
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

[hw/rtl/fvcw_div.sv]
// ----------------------------------------------------------------------------
// Saturation divider
// Restoring division with an 8-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fvcw_div #(
  parameter int DW = 25,
  parameter int VW = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [DW-1:0]                   dividend,
  input  logic [VW-1:0]                   divisor,
  output logic                            done,
  output logic [fvcw_pkg::COLOR_W-1:0]    quotient
);

  localparam int BW = $clog2(fvcw_pkg::COLOR_W);

  logic          busy;
  logic [BW-1:0] b;
  logic [DW-1:0] rem;
  logic [DW-1:0] trial;

  assign trial = DW'(divisor) << b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      b <= '0;
      done <= 1'b0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        quotient[b] <= 1'b1;
      end else begin
        quotient[b] <= 1'b0;
      end
      b <= b - 1'b1;
      done <= (b == '0);
      if (b == '0) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= dividend;
        b <= BW'(fvcw_pkg::COLOR_W - 1);
        busy <= 1'b1;
      end
    end
  end

endmodule

[hw/rtl/flow_vector_color_wheel.sv]
// ----------------------------------------------------------------------------
// Flow vector color wheel
// Optical-flow color coding: a measure pass tracks the largest flow
// magnitude of a frame and a color pass maps each vector to an RGB color.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel: flow_x and flow_y in s_tdata, the
// item kind and flags in s_tuser. A measure item produces no output item;
// a color item produces exactly one RGB item on the m_ channel.
// One item is worked on at a time; s_tready is high only while the block is
// free. A known measure item holds s_tready low until the square root unit,
// which retires two radicand bits per cycle, has finished.
// A color item runs through the square root, a CORDIC run of one rotation
// per cycle, then per channel a wheel blend, a multiply and a divide.
// A magnitude above the maximum skips the multiply and the divide for each
// channel, and a vector on an axis skips the CORDIC run.
// Unknown vectors and an empty maximum skip all of this and go straight to
// the output register.
// The finished color waits in an output register; a stalled receiver holds
// it there, and the next input item is still taken meanwhile, but a further
// result stalls until the register is free.
// Reset clears the stored maximum to zero and drops any pending output.
// ----------------------------------------------------------------------------
`include "flow_vector_color_wheel_defines.svh"

module flow_vector_color_wheel #(
  parameter int FLOW_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // flow_x, flow_y
  input  logic [((2*FLOW_WIDTH+7)/8)*8-1:0] s_tdata,
  // req_type, frame_start, flow_unknown
  input  logic [2:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // red, green, blue
  output logic [3*fvcw_pkg::COLOR_W-1:0] m_tdata
);

  localparam int W = FLOW_WIDTH;
  localparam int MAG_W = W + 1;
  localparam int NUM_W = fvcw_pkg::CVAL_W + MAG_W;
  localparam int PROD_W = fvcw_pkg::PHASE_W + 6;
  localparam int CW = fvcw_pkg::COLOR_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_PHASE, ST_WHEEL, ST_PROD, ST_NUM, ST_DIV, ST_NEXT, ST_EMIT
  } state_t;

  state_t                       state;
  logic                         req_r;
  logic signed [W-1:0]          x_r;
  logic signed [W-1:0]          y_r;
  logic [MAG_W-1:0]             max_magnitude;
  logic [W-1:0]                 m_r;
  logic [PROD_W-1:0]            prod;
  logic [1:0]                   ch;
  logic [fvcw_pkg::CVAL_W-1:0]  c;
  logic [NUM_W-1:0]             a_r;
  logic [NUM_W-1:0]             b_r;
  logic [NUM_W-1:0]             num_r;
  logic [CW-1:0]                chan [3];
  logic                         sq_start;
  logic                         sq_done;
  logic [W-1:0]                 sq_root;
  logic                         cd_start;
  logic                         cd_done;
  logic [fvcw_pkg::PHASE_W-1:0] cd_z;
  logic                         dv_start;
  logic                         dv_done;
  logic [CW-1:0]                dv_q;
  logic                         accept;

  logic [fvcw_pkg::WHEEL_IDX_W-1:0] k0;
  logic [fvcw_pkg::WHEEL_IDX_W-1:0] k1;
  logic [15:0]                      f;
  logic [16:0]                      inv_f;
  logic [3*CW-1:0]                  e0;
  logic [3*CW-1:0]                  e1;
  logic [CW-1:0]                    w0;
  logic [CW-1:0]                    w1;
  logic [24:0]                      p0;
  logic [24:0]                      p1;
  logic [fvcw_pkg::CVAL_W-1:0]      c_next;
  logic [25:0]                      tri_c;
  logic [MAG_W-1:0]                 m_ext;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_ext = MAG_W'(m_r);

  assign k0 = prod[PROD_W-1:fvcw_pkg::PHASE_W];
  assign k1 = (k0 == fvcw_pkg::WHEEL_LAST) ? '0 : k0 + 1'b1;
  assign f = prod[31:16];
  assign inv_f = 17'h10000 - {1'b0, f};
  assign e0 = fvcw_pkg::WHEEL_TAB[k0];
  assign e1 = fvcw_pkg::WHEEL_TAB[k1];

  always_comb begin
    case (ch)
      2'd0: begin
        w0 = e0[CW-1:0];
        w1 = e1[CW-1:0];
      end
      2'd1: begin
        w0 = e0[2*CW-1:CW];
        w1 = e1[2*CW-1:CW];
      end
      default: begin
        w0 = e0[3*CW-1:2*CW];
        w1 = e1[3*CW-1:2*CW];
      end
    endcase
  end

  assign p0 = 25'(inv_f * w0);
  assign p1 = 25'({1'b0, f} * w1);
  assign c_next = fvcw_pkg::CVAL_W'(p0 + p1);
  assign tri_c = {1'b0, c, 1'b0} + {2'b00, c};

  fvcw_sqrt #(.W(W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (x_r),
    .y     (y_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  fvcw_cordic #(.W(W), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cd_start),
    .x     (x_r),
    .y     (y_r),
    .done  (cd_done),
    .z     (cd_z)
  );

  fvcw_div #(.DW(NUM_W - 16), .VW(MAG_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (num_r[NUM_W-1:16]),
    .divisor  (max_magnitude),
    .done     (dv_done),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      max_magnitude <= '0;
      m_tvalid <= 1'b0;
      ch <= '0;
      sq_start <= 1'b0;
      cd_start <= 1'b0;
      dv_start <= 1'b0;
    end else begin
      if (sq_start) begin
        sq_start <= 1'b0;
      end
      if (cd_start) begin
        cd_start <= 1'b0;
      end
      if (dv_start) begin
        dv_start <= 1'b0;
      end
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req_r <= s_tuser[0];
            x_r <= s_tdata[W-1:0];
            y_r <= s_tdata[2*W-1:W];
            if (!s_tuser[0]) begin
              if (s_tuser[1]) begin
                max_magnitude <= '0;
              end
              if (!s_tuser[2]) begin
                sq_start <= 1'b1;
                state <= ST_MAG;
              end
            end else if (s_tuser[2]) begin
              chan[0] <= '0;
              chan[1] <= '0;
              chan[2] <= '0;
              state <= ST_EMIT;
            end else if (max_magnitude == '0) begin
              chan[0] <= '1;
              chan[1] <= '1;
              chan[2] <= '1;
              state <= ST_EMIT;
            end else begin
              sq_start <= 1'b1;
              state <= ST_MAG;
            end
          end
        end
        ST_MAG: begin
          if (sq_done) begin
            m_r <= sq_root;
            if (!req_r) begin
              if (MAG_W'(sq_root) > max_magnitude) begin
                max_magnitude <= MAG_W'(sq_root);
              end
              state <= ST_IDLE;
            end else begin
              cd_start <= 1'b1;
              state <= ST_PHASE;
            end
          end
        end
        ST_PHASE: begin
          if (cd_done) begin
            prod <= PROD_W'(cd_z * fvcw_pkg::WHEEL_SPAN);
            ch <= '0;
            state <= ST_WHEEL;
          end
        end
        ST_WHEEL: begin
          c <= c_next;
          state <= ST_PROD;
        end
        ST_PROD: begin
          if (m_ext <= max_magnitude) begin
            a_r <= NUM_W'(fvcw_pkg::FULL_Q16 * max_magnitude);
            b_r <= NUM_W'(m_ext * (fvcw_pkg::FULL_Q16 - c));
            state <= ST_NUM;
          end else begin
            chan[ch] <= tri_c[25:18];
            state <= ST_NEXT;
          end
        end
        ST_NUM: begin
          num_r <= a_r - b_r;
          dv_start <= 1'b1;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (dv_done) begin
            chan[ch] <= dv_q;
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (ch == 2'd2) begin
            state <= ST_EMIT;
          end else begin
            ch <= ch + 1'b1;
            state <= ST_WHEEL;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {chan[2], chan[1], chan[0]};
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `FVCW_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept && (s_tuser[0] || !s_tuser[2]), !s_tready, "accepted item did not make the block busy")
  `FVCW_ASSERT_NEXT(a_max_monotonic, clk, rst, !(accept && !s_tuser[0] && s_tuser[1]), max_magnitude >= $past(max_magnitude), "stored maximum fell without a frame start")
  `FVCW_ASSERT_NOW(a_emit_origin, clk, rst, $rose(m_tvalid), $past(state == ST_EMIT), "output item raised outside the emit step")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Flow vector color wheel testbench
// Streams measure and color items into the block, predicts every RGB color
// and compares it with the output stream. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_COLOR   = 1'b1;
  localparam int   TURN_STEPS  = 16;
  localparam int   STALL_LIMIT = 5000;
  localparam longint unsigned FULL_SCALE = 64'd255 * 64'd65536;

  localparam logic [31:0] ARC_TURNS [TURN_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  rgb_t            color_queue[$];
  longint unsigned peak_magnitude;
  int              errors;
  int              idle_cycles;
  bit              idling_on;

  flow_vector_color_wheel dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] flow_angle(longint signed x, longint signed y);
    logic [31:0] z;
    longint signed dx;
    longint signed dy;
    z = '0;
    if (y == 0) return (x < 0) ? 32'h80000000 : 32'h0;
    if (x == 0) return (y > 0) ? 32'h40000000 : 32'hC0000000;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < TURN_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TURNS[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TURNS[i];
      end
    end
    return z;
  endfunction

  // Channel 0 is red, 1 green, 2 blue.
  function automatic longint unsigned wheel_entry(int k, int ch);
    int r;
    int g;
    int b;
    r = 255;
    g = 0;
    b = 0;
    if (k < 15) begin
      g = 255 * k / 15;
    end else if (k < 21) begin
      r = 255 - 255 * (k - 15) / 6;
      g = 255;
    end else if (k < 25) begin
      r = 0;
      g = 255;
      b = 255 * (k - 21) / 4;
    end else if (k < 36) begin
      r = 0;
      g = 255 - 255 * (k - 25) / 11;
      b = 255;
    end else if (k < 49) begin
      r = 255 * (k - 36) / 13;
      b = 255;
    end else begin
      b = 255 - 255 * (k - 49) / 6;
    end
    return (ch == 0) ? r : (ch == 1) ? g : b;
  endfunction

  task automatic enqueue_color(rgb_t item);
    color_queue.insert(color_queue.size(), item);
  endtask

  task automatic predict_color(logic req, logic fs, logic unk, logic signed [15:0] fx,
                               logic signed [15:0] fy);
    longint signed   x;
    longint signed   y;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned frac;
    longint unsigned c;
    longint unsigned v;
    int              k0;
    int              k1;
    logic [7:0]      chan [3];
    x = fx;
    y = fy;
    mag = root_floor(x * x + y * y);
    if (req == REQ_MEASURE) begin
      if (fs) peak_magnitude = 0;
      if (!unk && (mag & 64'h1FFFF) > peak_magnitude) peak_magnitude = mag & 64'h1FFFF;
      return;
    end
    if (unk) begin
      enqueue_color('{8'd0, 8'd0, 8'd0});
      return;
    end
    if (peak_magnitude == 0) begin
      enqueue_color('{8'd255, 8'd255, 8'd255});
      return;
    end
    prod = {32'd0, flow_angle(x, y)} * 64'd54;
    k0 = int'(prod >> 32);
    k1 = (k0 + 1) % 55;
    frac = (prod >> 16) & 64'hFFFF;
    for (int ch = 0; ch < 3; ch++) begin
      c = (64'd65536 - frac) * wheel_entry(k0, ch) + frac * wheel_entry(k1, ch);
      if (mag <= peak_magnitude)
        v = (FULL_SCALE * peak_magnitude - mag * (FULL_SCALE - c)) /
            (64'd65536 * peak_magnitude);
      else
        v = (c * 3) >> 18;
      chan[ch] = v[7:0];
    end
    enqueue_color('{chan[2], chan[1], chan[0]});
  endtask

  task automatic send_item(logic req, logic fs, logic unk, logic signed [15:0] fx,
                           logic signed [15:0] fy);
    int gap;
    gap = idling_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {fy, fx};
    s_tuser  <= {unk, fs, req};
    do @(posedge clk); while (!s_tready);
    predict_color(req, fs, unk, fx, fy);
  endtask

  function automatic logic signed [15:0] random_flow();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 510)) - 255);
      2: return 16'($signed($urandom_range(0, 8190)) - 4095);
      3: return 16'($signed($urandom_range(0, 60)) - 30);
      default: return 16'($urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? 32767 : -32768));
    endcase
  endfunction

  task automatic test_empty_and_unknown();
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd5, 16'sd3);
    send_item(REQ_COLOR, 1'b0, 1'b1, 16'sd5, 16'sd3);
    send_item(REQ_MEASURE, 1'b1, 1'b1, 16'sd100, 16'sd100);
    send_item(REQ_COLOR, 1'b0, 1'b0, -16'sd7, 16'sd9);
  endtask

  task automatic test_extremes();
    send_item(REQ_MEASURE, 1'b1, 1'b0, -16'sd32768, -16'sd32768);
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd32767, 16'sd0);
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd0, 16'sd32767);
    send_item(REQ_COLOR, 1'b0, 1'b0, -16'sd32768, 16'sd0);
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd0, -16'sd32768);
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_item(REQ_COLOR, 1'b0, 1'b0, -16'sd32768, -16'sd32768);
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd32767, 16'sd32767);
    send_item(REQ_COLOR, 1'b1, 1'b0, 16'sd100, -16'sd100);
    send_item(REQ_COLOR, 1'b1, 1'b1, -16'sd1, 16'sd1);
  endtask

  task automatic test_out_of_range();
    send_item(REQ_MEASURE, 1'b1, 1'b0, 16'sd16, 16'sd0);
    send_item(REQ_MEASURE, 1'b0, 1'b0, 16'sd0, -16'sd12);
    send_item(REQ_MEASURE, 1'b0, 1'b1, 16'sd30000, 16'sd0);
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd300, 16'sd400);
    send_item(REQ_COLOR, 1'b0, 1'b0, -16'sd5, 16'sd7);
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd16, 16'sd0);
    send_item(REQ_COLOR, 1'b0, 1'b0, 16'sd11, -16'sd12);
  endtask

  task automatic test_random_frames(int target);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      idling_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        send_item(REQ_MEASURE, i == 0, $urandom_range(0, 9) == 0, random_flow(),
                  random_flow());
      end
      sent += n;
      n = $urandom_range(1, 15);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(1'($urandom), 1'($urandom), 1'($urandom), random_flow(),
                    random_flow());
        else
          send_item(REQ_COLOR, 1'($urandom), $urandom_range(0, 9) == 0, random_flow(),
                    random_flow());
      end
      sent += n;
    end
  endtask

  initial begin
    m_tready = 1'b1;
    forever begin
      int stall;
      stall = idling_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (color_queue.size() == 0) begin
        $display("%0t: unexpected color item %h", $time, got);
        errors++;
      end else begin
        want = color_queue.pop_front();
        if (got.red !== want.red)
          $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        if (got !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("flow_vector_color_wheel test failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    errors = 0;
    idle_cycles = 0;
    idling_on = 1'b1;
    peak_magnitude = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_unknown();
    test_extremes();
    test_out_of_range();
    test_random_frames(650);
    s_tvalid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && color_queue.size() == 0) begin
      $display("flow_vector_color_wheel test passed");
    end else begin
      $display("flow_vector_color_wheel test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fvcw_pkg.sv
hw/rtl/fvcw_sqrt.sv
hw/rtl/fvcw_cordic.sv
hw/rtl/fvcw_div.sv
hw/rtl/flow_vector_color_wheel.sv
tb/testbench.sv
